### rtl/tdei_pkg.sv
// Package with shared types and constants for the table-driven error injector.
package tdei_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int VALUE_WIDTH = 16;
	localparam int LEN_W = 11;
	localparam int WOFF_W = 15;
	localparam int RAND_W = 31;
	localparam int CNT_W = 16;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 15;

	localparam logic [CFG_IDX_W-1:0] REG_TABLE_LENGTH = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_OFFSET = 1'd1;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_APPLY = 1'b1;

	typedef struct packed {
		logic                        cmd;
		logic [9:0]                  row_index;
		logic signed [VALUE_WIDTH-1:0] row_key;
		logic [15:0]                 row_count;
		logic signed [VALUE_WIDTH-1:0] row_error;
		logic signed [VALUE_WIDTH-1:0] sample_value;
		logic [30:0]                 random_draw;
	} in_item_t;

	typedef struct packed {
		logic signed [VALUE_WIDTH-1:0] result_value;
		logic                          error_flag;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN_RD,
		ST_SCAN,
		ST_UPPER_RD,
		ST_MOD,
		ST_WALK_RD,
		ST_WALK,
		ST_DONE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic write_row;
		logic scan_rd;
		logic scan_eval;
		logic upper_rd;
		logic mod_start;
		logic walk_init;
		logic walk_rd;
		logic walk_eval;
		logic finish_pass;
		logic finish_err;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic scan_last;
		logic stop_hit;
		logic upper_zero;
		logic mod_done;
		logic walk_empty;
	} dp_sts_t;

endpackage

### rtl/tdei_ctrl.sv
// Controller state machine for the error injector.
module tdei_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               cmd,
	input  tdei_pkg::dp_sts_t  sts,
	output tdei_pkg::dp_cmd_t  ctl,
	output logic               busy,
	output logic               done
);

	tdei_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tdei_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ctl = '0;
		busy = 1'b1;
		done = 1'b0;
		case (state_q)
			tdei_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					if (cmd == tdei_pkg::CMD_WRITE) begin
						ctl.write_row = 1'b1;
					end else begin
						ctl.load = 1'b1;
						state_d = tdei_pkg::ST_SCAN_RD;
					end
				end
			end
			tdei_pkg::ST_SCAN_RD: begin
				if (sts.scan_last) begin
					ctl.upper_rd = 1'b1;
					state_d = tdei_pkg::ST_UPPER_RD;
				end else begin
					ctl.scan_rd = 1'b1;
					state_d = tdei_pkg::ST_SCAN;
				end
			end
			tdei_pkg::ST_SCAN: begin
				ctl.scan_eval = 1'b1;
				if (sts.stop_hit) begin
					ctl.upper_rd = 1'b1;
					state_d = tdei_pkg::ST_UPPER_RD;
				end else begin
					state_d = tdei_pkg::ST_SCAN_RD;
				end
			end
			tdei_pkg::ST_UPPER_RD: begin
				if (sts.upper_zero) begin
					ctl.finish_pass = 1'b1;
					state_d = tdei_pkg::ST_DONE;
				end else begin
					ctl.mod_start = 1'b1;
					state_d = tdei_pkg::ST_MOD;
				end
			end
			tdei_pkg::ST_MOD: begin
				if (sts.mod_done) begin
					ctl.walk_init = 1'b1;
					state_d = tdei_pkg::ST_WALK_RD;
				end
			end
			tdei_pkg::ST_WALK_RD: begin
				if (sts.walk_empty) begin
					ctl.finish_err = 1'b1;
					state_d = tdei_pkg::ST_DONE;
				end else begin
					ctl.walk_rd = 1'b1;
					state_d = tdei_pkg::ST_WALK;
				end
			end
			tdei_pkg::ST_WALK: begin
				ctl.walk_eval = 1'b1;
				state_d = tdei_pkg::ST_WALK_RD;
			end
			tdei_pkg::ST_DONE: begin
				done = 1'b1;
				state_d = tdei_pkg::ST_IDLE;
			end
			default: begin
				state_d = tdei_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

### rtl/tdei_dp.sv
// Datapath of the error injector: table memories, scan, modulo and walk.
module tdei_dp #(
	parameter int TABLE_DEPTH = tdei_pkg::TABLE_DEPTH
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  tdei_pkg::dp_cmd_t                       ctl,
	output tdei_pkg::dp_sts_t                       sts,
	input  tdei_pkg::in_item_t                      item,
	input  logic [tdei_pkg::LEN_W-1:0]              table_length,
	input  logic [tdei_pkg::WOFF_W-1:0]             window_offset,
	output logic signed [tdei_pkg::VALUE_WIDTH-1:0] result_value,
	output logic                                    error_flag
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int IW = AW + 1;
	localparam int CW = tdei_pkg::CNT_W;
	localparam int RW = tdei_pkg::RAND_W;
	localparam int VW = tdei_pkg::VALUE_WIDTH;

	logic signed [VW-1:0] key_mem [TABLE_DEPTH];
	logic [CW-1:0]        cnt_mem [TABLE_DEPTH];
	logic signed [VW-1:0] err_mem [TABLE_DEPTH];

	// Two-row window read for the scan; single row read for upper and walk.
	logic signed [VW-1:0] k0_q, k1_q, err_rd_q;
	logic [CW-1:0]        c0_q, c1_q;
	logic [AW-1:0]        rd0_a, rd1_a;

	logic [IW-1:0]        i_q, lower_q, upper_q, len_q;
	logic signed [VW-1:0] v_q;
	logic signed [VW+1:0] lo_q;
	logic [RW-1:0]        rnd_q;
	logic [CW-1:0]        div_q;
	logic [RW-1:0]        rem_q;
	logic [4:0]           mbit_q;
	logic                 mod_busy_q;
	logic signed [VW-1:0] err_q;
	logic                 flag_q, stopped_q;

	logic [AW-1:0] idx_w;
	assign idx_w = AW'(item.row_index);

	always_ff @(posedge clk) begin
		if (ctl.write_row) begin
			key_mem[idx_w] <= VW'(item.row_key);
			cnt_mem[idx_w] <= item.row_count;
			err_mem[idx_w] <= VW'(item.row_error);
		end
	end

	always_comb begin
		rd0_a = i_q[AW-1:0];
		rd1_a = AW'(i_q + IW'(1));
		if (ctl.upper_rd) begin
			rd0_a = ctl.scan_eval ? i_q[AW-1:0] : upper_q[AW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.scan_rd || ctl.upper_rd || ctl.walk_rd) begin
			k0_q     <= key_mem[rd0_a];
			c0_q     <= cnt_mem[rd0_a];
			err_rd_q <= err_mem[rd0_a];
			k1_q     <= key_mem[rd1_a];
			c1_q     <= cnt_mem[rd1_a];
		end
	end

	// Scan decisions on the registered row pair.
	logic signed [VW+1:0] k0x, k1x, vx;
	logic                 lower_hit, stop;
	always_comb begin
		k0x = (VW+2)'(k0_q);
		k1x = (VW+2)'(k1_q);
		vx  = (VW+2)'(v_q);
		if (v_q == '0) begin
			lower_hit = (k1_q == '0) && (k0_q < 0);
			stop = (k0_q == '0) && ((k1_q > 0) || (c1_q == '0));
		end else begin
			if ((v_q < 0) || (k0_q > 0)) begin
				lower_hit = (k1x > lo_q) && (k0x <= lo_q);
			end else begin
				lower_hit = (k1_q > 0) && (k1x > lo_q);
			end
			stop = (k0x <= vx) && ((k1x > vx) || (c1_q == '0));
		end
	end

	// Restoring divider: one quotient bit per cycle.
	logic [RW:0] trial;
	assign trial = {rem_q, rnd_q[mbit_q]} - (RW+1)'(div_q);

	logic signed [VW+1:0] sum;
	logic signed [VW-1:0] smax, smin;
	assign smax = {1'b0, {(VW-1){1'b1}}};
	assign smin = {1'b1, {(VW-1){1'b0}}};
	assign sum = (VW+2)'(v_q) + (VW+2)'(err_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q <= '0;
			mod_busy_q <= 1'b0;
			mbit_q <= '0;
			stopped_q <= 1'b0;
		end else begin
			if (ctl.load) begin
				i_q <= '0;
			end else if (ctl.scan_eval && !stop) begin
				i_q <= i_q + IW'(1);
			end
			if (ctl.mod_start) begin
				mod_busy_q <= 1'b1;
				mbit_q <= 5'(RW - 1);
			end else if (mod_busy_q) begin
				if (mbit_q == '0) begin
					mod_busy_q <= 1'b0;
				end else begin
					mbit_q <= mbit_q - 5'd1;
				end
			end
			if (ctl.walk_init) begin
				i_q <= lower_q;
				stopped_q <= 1'b0;
			end else if (ctl.walk_eval) begin
				i_q <= i_q + IW'(1);
				if (c0_q > rem_q[CW-1:0] && rem_q[RW-1:CW] == '0) begin
					stopped_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			v_q <= VW'(item.sample_value);
			lo_q <= (VW+2)'(item.sample_value) - (VW+2)'(window_offset);
			rnd_q <= item.random_draw;
			len_q <= (table_length > IW'(TABLE_DEPTH)) ? IW'(TABLE_DEPTH) : IW'(table_length);
			lower_q <= '0;
			upper_q <= '0;
			err_q <= '0;
			flag_q <= 1'b0;
		end
		if (ctl.scan_eval) begin
			if (lower_hit) lower_q <= i_q + IW'(1);
			if (stop) upper_q <= i_q;
		end
		if (ctl.upper_rd) begin
			div_q <= '0;
		end
		if (ctl.mod_start) begin
			div_q <= c0_q;
			rem_q <= '0;
		end else if (mod_busy_q) begin
			rem_q <= trial[RW] ? {rem_q[RW-2:0], rnd_q[mbit_q]} : trial[RW-1:0];
		end
		if (ctl.walk_eval) begin
			err_q <= err_rd_q;
			if (err_rd_q != '0) flag_q <= 1'b1;
		end
		if (ctl.finish_pass) begin
			result_value <= v_q;
			error_flag <= 1'b0;
		end
		if (ctl.finish_err) begin
			result_value <= (sum > (VW+2)'(smax)) ? smax :
				(sum < (VW+2)'(smin)) ? smin : VW'(sum);
			error_flag <= flag_q;
		end
	end

	assign sts.scan_last  = (i_q + IW'(1) >= len_q);
	assign sts.stop_hit   = stop;
	assign sts.upper_zero = (c0_q == '0);
	assign sts.mod_done   = mod_busy_q && (mbit_q == '0);
	assign sts.walk_empty = stopped_q || (i_q > upper_q);

endmodule

### rtl/table_driven_error_injector_core.sv
// A write item is taken while idle and writes one table row; an apply item scans the rows
// (up to table_length-1 rows), reads the upper row, runs the modulo divider, walks the
// selected rows with a final check and then registers the result.
// One item at a time; the row scan and the selection walk take most of the time.
// The result is shown for one cycle with done; the receiver cannot stall.
// Reset clears control state, the config registers and some datapath registers; table rows are undefined.
module table_driven_error_injector_core #(
	parameter int TABLE_DEPTH = tdei_pkg::TABLE_DEPTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  tdei_pkg::in_item_t                  in_item,
	output logic                                done,
	output tdei_pkg::out_item_t                 out_item,
	input  logic                                cfg_we,
	input  logic [tdei_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tdei_pkg::CFG_DATA_W-1:0]     cfg_data
);

	logic [tdei_pkg::LEN_W-1:0]  table_length_q;
	logic [tdei_pkg::WOFF_W-1:0] window_offset_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_length_q <= tdei_pkg::LEN_W'(2);
			window_offset_q <= tdei_pkg::WOFF_W'(75);
		end else if (cfg_we) begin
			case (cfg_index)
				tdei_pkg::REG_TABLE_LENGTH: table_length_q <= tdei_pkg::LEN_W'(cfg_data);
				tdei_pkg::REG_WINDOW_OFFSET: window_offset_q <= cfg_data;
				default: ;
			endcase
		end
	end

	tdei_pkg::dp_cmd_t ctl;
	tdei_pkg::dp_sts_t sts;
	logic signed [tdei_pkg::VALUE_WIDTH-1:0] res_v;
	logic res_f;

	tdei_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .cmd(in_item.cmd),
		.sts(sts), .ctl(ctl), .busy(busy), .done(done)
	);

	tdei_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .sts(sts), .item(in_item),
		.table_length(table_length_q), .window_offset(window_offset_q),
		.result_value(res_v), .error_flag(res_f)
	);

	assign out_item.result_value = res_v;
	assign out_item.error_flag = res_f;

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held two cycles");
	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("done while idle");
	a_no_start_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && in_item.cmd == tdei_pkg::CMD_WRITE) |=> !done)
		else $error("result for a write item");

endmodule
